### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Types and constants shared by the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  localparam int COORD_MAX_W = 32;
  localparam int ID_MAX_W    = 32;
  localparam int DIFF_W      = COORD_MAX_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int CNT_W       = 3;

  localparam logic [CNT_W-1:0] MIN_VERTICES = CNT_W'(4);

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_OPEN  = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  typedef struct packed {
    logic                          first;
    logic                          last;
    logic signed [COORD_MAX_W-1:0] vertex_x;
    logic signed [COORD_MAX_W-1:0] vertex_y;
    logic        [ID_MAX_W-1:0]    vertex_id;
    logic signed [COORD_MAX_W-1:0] point_x;
    logic signed [COORD_MAX_W-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic                     first;
    logic                     last;
    status_t                  status;
    logic signed [DIFF_W-1:0] dx0;
    logic signed [DIFF_W-1:0] dx1;
    logic signed [DIFF_W-1:0] dy0;
    logic signed [DIFF_W-1:0] dy1;
  } seg_t;

  typedef struct packed {
    logic                     first;
    logic                     last;
    status_t                  status;
    logic                     test_en;
    logic                     dx1_pos;
    logic signed [PROD_W-1:0] prod_a;
    logic signed [PROD_W-1:0] prod_b;
  } stg_t;

endpackage

`default_nettype wire

### rtl/pip_fifo.sv
// ----------------------------------------------------------------------------
// pip_fifo
// Small first-in first-out queue with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wr_data,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo occupancy above depth");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("fifo count missed a write");

endmodule

`default_nettype wire

### rtl/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front
// Vertex intake: tracks test point, previous vertex, start id and count;
// forms edge offsets and polygon status for each vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_front #(
  parameter int COORD_WIDTH = 32,
  parameter int ID_WIDTH    = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  pip_pkg::in_item_t in_item,
  output logic              seg_push,
  output pip_pkg::seg_t     seg_item,
  input  logic              seg_full
);

  import pip_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r, test_x_r, test_y_r;
  logic signed [COORD_WIDTH-1:0] test_x_nxt, test_y_nxt;
  logic signed [COORD_WIDTH-1:0] vx, vy, px, py;
  logic        [ID_WIDTH-1:0]    start_id_r, start_id_nxt, vid;
  logic        [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic signed [DW-1:0]          dx0_w, dx1_w, dy0_w, dy1_w;
  logic                          accept;
  status_t                       status;

  assign vx  = in_item.vertex_x[COORD_WIDTH-1:0];
  assign vy  = in_item.vertex_y[COORD_WIDTH-1:0];
  assign px  = in_item.point_x[COORD_WIDTH-1:0];
  assign py  = in_item.point_y[COORD_WIDTH-1:0];
  assign vid = in_item.vertex_id[ID_WIDTH-1:0];

  assign accept   = push && !seg_full;
  assign full     = seg_full;
  assign seg_push = push;

  assign dx0_w = DW'(prev_x_r) - DW'(test_x_r);
  assign dx1_w = DW'(vx) - DW'(test_x_r);
  assign dy0_w = DW'(prev_y_r) - DW'(test_y_r);
  assign dy1_w = DW'(vy) - DW'(test_y_r);

  always_comb begin
    if (in_item.first) begin
      test_x_nxt   = px;
      test_y_nxt   = py;
      start_id_nxt = vid;
      cnt_nxt      = CNT_W'(1);
    end else begin
      test_x_nxt   = test_x_r;
      test_y_nxt   = test_y_r;
      start_id_nxt = start_id_r;
      cnt_nxt      = (cnt_r < MIN_VERTICES) ? cnt_r + CNT_W'(1) : cnt_r;
    end
    if (start_id_nxt != vid) begin
      status = ST_OPEN;
    end else if (cnt_nxt < MIN_VERTICES) begin
      status = ST_SHORT;
    end else begin
      status = ST_VALID;
    end
  end

  always_comb begin
    seg_item.first  = in_item.first;
    seg_item.last   = in_item.last;
    seg_item.status = status;
    seg_item.dx0    = DIFF_W'(dx0_w);
    seg_item.dx1    = DIFF_W'(dx1_w);
    seg_item.dy0    = DIFF_W'(dy0_w);
    seg_item.dy1    = DIFF_W'(dy1_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      test_x_r   <= '0;
      test_y_r   <= '0;
      start_id_r <= '0;
      cnt_r      <= '0;
    end else if (accept) begin
      prev_x_r   <= vx;
      prev_y_r   <= vy;
      test_x_r   <= test_x_nxt;
      test_y_r   <= test_y_nxt;
      start_id_r <= start_id_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/pip_back.sv
// ----------------------------------------------------------------------------
// pip_back
// Edge evaluation: cross products, height sign test, crossing parity and
// result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             mid_empty,
  input  pip_pkg::seg_t                    mid_item,
  output logic                             mid_pop,
  output logic                             res_push,
  output pip_pkg::out_item_t               res_item,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   res_count
);

  import pip_pkg::*;

  localparam int OCW = $clog2(OUT_DEPTH + 1);

  stg_t                     s1_r, s1_nxt;
  logic                     s1_valid_r;
  logic                     parity_r, parity_nxt;
  logic                     pending;
  logic [OCW:0]             credit_use;
  logic                     dx0_neg, dx0_zero, dx1_neg, dx1_zero, straddle;
  logic signed [PROD_W-1:0] pa, pb;
  logic signed [SUM_W-1:0]  diff;
  logic                     s_pos, s_neg, ray_hit;

  assign pending    = s1_valid_r && s1_r.last;
  assign credit_use = (OCW + 1)'(res_count) + (OCW + 1)'(pending);
  assign mid_pop    = !mid_empty && (credit_use < (OCW + 1)'(OUT_DEPTH));

  assign dx0_neg  = mid_item.dx0[DIFF_W-1];
  assign dx0_zero = (mid_item.dx0 == '0);
  assign dx1_neg  = mid_item.dx1[DIFF_W-1];
  assign dx1_zero = (mid_item.dx1 == '0);
  assign straddle = ((dx0_neg || dx0_zero) && !dx1_neg) ||
                    (!dx0_neg && (dx1_neg || dx1_zero));

  always_comb begin
    s1_nxt.first   = mid_item.first;
    s1_nxt.last    = mid_item.last;
    s1_nxt.status  = mid_item.status;
    s1_nxt.test_en = !mid_item.first && straddle && !dx1_zero;
    s1_nxt.dx1_pos = !dx1_neg;
    s1_nxt.prod_a  = $signed(mid_item.dx1) * $signed(mid_item.dy0);
    s1_nxt.prod_b  = $signed(mid_item.dx0) * $signed(mid_item.dy1);
  end

  assign pa      = s1_r.prod_a;
  assign pb      = s1_r.prod_b;
  assign diff    = SUM_W'(pa) - SUM_W'(pb);
  assign s_neg   = diff[SUM_W-1];
  assign s_pos   = !diff[SUM_W-1] && (diff != '0);
  assign ray_hit = s1_r.test_en && (s1_r.dx1_pos ? s_pos : s_neg);

  always_comb begin
    parity_nxt = parity_r;
    if (s1_valid_r) begin
      parity_nxt = s1_r.first ? 1'b0 : (parity_r ^ ray_hit);
    end
  end

  assign res_push            = pending;
  assign res_item.inside_res = (s1_r.status == ST_VALID) && parity_nxt;
  assign res_item.status     = s1_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      parity_r   <= 1'b0;
    end else begin
      s1_valid_r <= mid_pop;
      parity_r   <= parity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_r <= s1_nxt;
    end
  end

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    pending |-> (res_count < OCW'(OUT_DEPTH)))
    else $error("result written with no room in output queue");

  a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.first) |=> !parity_r)
    else $error("parity not cleared on first vertex");

endmodule

`default_nettype wire

### rtl/point_in_polygon_crossing.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing
// Crossing-number point-in-polygon test over a streamed vertex list.
// ----------------------------------------------------------------------------
// Vertices enter one per cycle while full is low, through a queue-style port; the
// vertex marked first also carries the test point, and the vertex marked last
// produces one result (inside flag and status) on the output queue after the vertex
// queue and the registered product stage, or later if the output side stalls. The
// block sustains one vertex per clock; throughput is set by the single registered
// 33x33-bit product pair of the edge evaluator, and the intake keeps running while
// that stage or the output queue holds back, until the internal vertex queue fills.
`default_nettype none

module point_in_polygon_crossing #(
  parameter int COORD_WIDTH = 32,
  parameter int ID_WIDTH    = 32,
  parameter int MID_DEPTH   = 4,
  parameter int OUT_DEPTH   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  pip_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output pip_pkg::out_item_t out_item
);

  import pip_pkg::*;

  localparam int MCW = $clog2(MID_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic      seg_push, seg_full;
  seg_t      seg_item;
  logic      mid_empty, mid_pop;
  seg_t      mid_item;
  logic [MCW-1:0] mid_count;
  logic      res_push, res_full;
  out_item_t res_item;
  logic [OCW-1:0] res_count;

  pip_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .seg_push (seg_push),
    .seg_item (seg_item),
    .seg_full (seg_full)
  );

  pip_fifo #(
    .WIDTH ($bits(seg_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (seg_push),
    .wr_data (seg_item),
    .full    (seg_full),
    .pop     (mid_pop),
    .rd_data (mid_item),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  pip_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_count (res_count)
  );

  pip_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_item),
    .empty   (empty),
    .count   (res_count)
  );

  a_mid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_count <= MCW'(MID_DEPTH)) && !(res_push && res_full))
    else $error("queue overrun between front and back");

endmodule

`default_nettype wire

### tb/point_in_polygon_crossing_tb.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_tb
// Streams polygons through the crossing-number point-in-polygon test and
// checks every verdict against a cycle-free predictor of the edge crossings,
// the closure check and the vertex count, under random back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

class polygon_tracker;
  logic signed [31:0] prev_x, prev_y, test_x, test_y;
  logic        [31:0] start_id;
  logic        [2:0]  vertex_count;
  logic               crossing_parity;
  pip_pkg::out_item_t pending_verdicts[$];
  int                 errors, verdicts, vertices, starts;

  function new();
    prev_x = '0;
    prev_y = '0;
    test_x = '0;
    test_y = '0;
    start_id = '0;
    vertex_count = '0;
    crossing_parity = 1'b0;
    errors = 0;
    verdicts = 0;
    vertices = 0;
    starts = 0;
  endfunction

  function void take_vertex(pip_pkg::in_item_t v);
    logic signed [31:0] vx, vy;
    logic signed [67:0] dx0, dx1, dy0, dy1, xprod;
    pip_pkg::status_t   stat;
    pip_pkg::out_item_t verdict;
    vx = v.vertex_x;
    vy = v.vertex_y;
    vertices++;
    if (v.first) begin
      test_x = v.point_x;
      test_y = v.point_y;
      start_id = v.vertex_id;
      vertex_count = 3'd1;
      crossing_parity = 1'b0;
      starts++;
    end else begin
      dx0 = prev_x - test_x;
      dx1 = vx - test_x;
      dy0 = prev_y - test_y;
      dy1 = vy - test_y;
      xprod = dx1 * dy0 - dx0 * dy1;
      if (((dx0 <= 0 && dx1 >= 0) || (dx0 >= 0 && dx1 <= 0)) && dx1 != 0) begin
        if ((dx1 > 0 && xprod > 0) || (dx1 < 0 && xprod < 0))
          crossing_parity = ~crossing_parity;
      end
      if (vertex_count < pip_pkg::MIN_VERTICES)
        vertex_count = vertex_count + 3'd1;
    end
    prev_x = vx;
    prev_y = vy;
    if (v.last) begin
      if (start_id != v.vertex_id)
        stat = pip_pkg::ST_OPEN;
      else if (vertex_count < pip_pkg::MIN_VERTICES)
        stat = pip_pkg::ST_SHORT;
      else
        stat = pip_pkg::ST_VALID;
      verdict.inside_res = (stat == pip_pkg::ST_VALID) ? crossing_parity : 1'b0;
      verdict.status = stat;
      pending_verdicts.push_back(verdict);
    end
  endfunction

  function void check_verdict(pip_pkg::out_item_t got);
    pip_pkg::out_item_t want;
    verdicts++;
    if (pending_verdicts.size() == 0) begin
      errors++;
      $display("%0t unexpected verdict: inside_res %0b status %0d", $time,
               got.inside_res, got.status);
    end else begin
      want = pending_verdicts.pop_front();
      if (got.inside_res !== want.inside_res) begin
        errors++;
        $display("%0t inside_res mismatch: expected %0b actual %0b", $time,
                 want.inside_res, got.inside_res);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t status mismatch: expected %0d actual %0d", $time,
                 want.status, got.status);
      end
    end
  endfunction
endclass

module point_in_polygon_crossing_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  localparam logic [31:0] MIN_C = 32'h8000_0000;
  localparam logic [31:0] MAX_C = 32'h7fff_ffff;
  localparam int          WATCHDOG_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full, empty;
  in_item_t  in_item = '0;
  out_item_t out_item;

  int source_gap_pct = 13;
  int sink_stall_pct = 71;
  int stall_cycles = 0;

  polygon_tracker tracker = new();

  point_in_polygon_crossing dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      tracker.check_verdict(out_item);
    pop <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord(input int mode);
    case (mode)
      0: pick_coord = ($urandom_range(8) - 4) << 16;
      1: pick_coord = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      2: pick_coord = $urandom();
      default: begin
        case ($urandom_range(4))
          0: pick_coord = MIN_C;
          1: pick_coord = MAX_C;
          2: pick_coord = 32'h0;
          3: pick_coord = 32'hffff_ffff;
          default: pick_coord = 32'h1;
        endcase
      end
    endcase
  endfunction

  task automatic send_vertex(input logic is_first, input logic is_last,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] id, input logic [31:0] px,
                             input logic [31:0] py);
    in_item_t v;
    v.first = is_first;
    v.last = is_last;
    v.vertex_x = x;
    v.vertex_y = y;
    v.vertex_id = id;
    v.point_x = px;
    v.point_y = py;
    while ($urandom_range(99) < source_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= v;
    do @(posedge clk); while (full);
    tracker.take_vertex(v);
  endtask

  task automatic send_polygon(input int n, input int mode, input bit closed);
    logic [31:0] x0, y0, id0, px, py;
    x0 = pick_coord(mode);
    y0 = pick_coord(mode);
    px = pick_coord(mode);
    py = pick_coord(mode);
    id0 = $urandom();
    send_vertex(1'b1, 1'b0, x0, y0, id0, px, py);
    repeat (n - 1)
      send_vertex(1'b0, 1'b0, pick_coord(mode), pick_coord(mode), $urandom(),
                  $urandom(), $urandom());
    send_vertex(1'b0, 1'b1, x0, y0,
                closed ? id0 : id0 ^ $urandom_range(32'hffff, 1),
                $urandom(), $urandom());
  endtask

  initial begin
    int kind;
    int mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray edge straight out of reset, then close against the cleared id
    send_vertex(1'b0, 1'b0, MAX_C, MIN_C, 32'hffff_ffff, MAX_C, MIN_C);
    send_vertex(1'b0, 1'b1, MIN_C, MAX_C, 32'h0, MIN_C, MAX_C);
    // single-vertex polygon
    send_vertex(1'b1, 1'b1, MIN_C, MAX_C, 32'hffff_ffff, MAX_C, MAX_C);
    // full-range square around the origin
    send_vertex(1'b1, 1'b0, MIN_C, MIN_C, 32'h5555_5555, 32'h0, 32'h0);
    send_vertex(1'b0, 1'b0, MAX_C, MIN_C, 32'haaaa_aaaa, MAX_C, MAX_C);
    send_vertex(1'b0, 1'b0, MAX_C, MAX_C, 32'hffff_ffff, MIN_C, MIN_C);
    send_vertex(1'b0, 1'b0, MIN_C, MAX_C, 32'h0, MAX_C, MIN_C);
    send_vertex(1'b0, 1'b1, MIN_C, MIN_C, 32'h5555_5555, MIN_C, MAX_C);
    // extra edges after last with no new first
    send_vertex(1'b0, 1'b0, 32'h0, 32'h0, 32'h1234_5678, 32'h0, 32'h0);
    send_vertex(1'b0, 1'b1, MIN_C, MIN_C, 32'h5555_5555, 32'h0, 32'h0);
    // test point at the extremes, polygon left open
    send_vertex(1'b1, 1'b0, 32'h0, 32'h0, 32'h1, MAX_C, MIN_C);
    send_vertex(1'b0, 1'b0, MAX_C, MAX_C, 32'h3, 32'h0, 32'h0);
    send_vertex(1'b0, 1'b0, MIN_C, MIN_C, 32'h4, 32'h0, 32'h0);
    send_vertex(1'b0, 1'b1, 32'h0, 32'h0, 32'h2, 32'h0, 32'h0);
    // closed but too few vertices
    send_vertex(1'b1, 1'b0, 32'h0001_0000, 32'h0, 32'h7, 32'h0, 32'h0);
    send_vertex(1'b0, 1'b0, 32'h0, 32'h0001_0000, 32'h8, 32'h0, 32'h0);
    send_vertex(1'b0, 1'b1, 32'h0001_0000, 32'h0, 32'h7, 32'h0, 32'h0);

    while (tracker.vertices < 1800) begin
      if (tracker.vertices >= 1200) begin
        source_gap_pct = 0;
        sink_stall_pct = 0;
      end else if (tracker.vertices >= 600) begin
        source_gap_pct = 71;
        sink_stall_pct = 13;
      end
      kind = $urandom_range(99);
      mode = $urandom_range(9);
      mode = (mode < 4) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
      if (kind < 70)
        send_polygon($urandom_range(8, 3), mode, 1'b1);
      else if (kind < 78)
        send_polygon($urandom_range(8, 2), mode, 1'b0);
      else if (kind < 84) begin
        if ($urandom_range(1))
          send_vertex(1'b1, 1'b1, pick_coord(mode), pick_coord(mode), $urandom(),
                      pick_coord(mode), pick_coord(mode));
        else
          send_polygon($urandom_range(2, 1), mode, 1'b1);
      end else if (kind < 92) begin
        repeat ($urandom_range(3, 1))
          send_vertex(1'b0, 1'($urandom_range(1)), pick_coord(mode),
                      pick_coord(mode), $urandom(), $urandom(), $urandom());
      end else
        send_vertex(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom());
    end
    push <= 1'b0;
    sink_stall_pct = 0;

    while (tracker.pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d vertices over %0d polygon starts under three idling mixes;",
             tracker.vertices, tracker.starts);
    $display("%0d verdicts checked, %0d mismatches, %0d verdicts still owed",
             tracker.verdicts, tracker.errors, tracker.pending_verdicts.size());
    if (tracker.errors == 0 && tracker.pending_verdicts.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

`default_nettype wire

### files.f
rtl/pip_pkg.sv
rtl/pip_fifo.sv
rtl/pip_front.sv
rtl/pip_back.sv
rtl/point_in_polygon_crossing.sv
tb/point_in_polygon_crossing_tb.sv
